>>> rtl/kvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvs_pkg: shared types and constants of the bucketed key-value store
// Field widths, table geometry, request and status codes, sequencer states
// and the reciprocal constants used by the bucket hash.
// ----------------------------------------------------------------------------
package kvs_pkg;

  // request and response field widths
  localparam int OP_W      = 2;
  localparam int KEY_W     = 31;
  localparam int VAL_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 8;

  // table geometry
  localparam int NUM_BUCKETS = 32;
  localparam int WAYS        = 4;
  localparam int TOTAL_SLOTS = NUM_BUCKETS * WAYS;
  localparam int SLOT_W      = $clog2(TOTAL_SLOTS);
  localparam int BUCKET_W    = $clog2(NUM_BUCKETS);
  localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAYC_W      = $clog2(WAYS + 1);
  localparam int CNT_W       = $clog2(TOTAL_SLOTS + 1);
  localparam int CNT_OUT_MAX = 255;
  localparam int KV_W        = KEY_W + VAL_W;

  // shared multiplier
  localparam int MUL_A_W = 31;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // key div 10000 estimate: (key * Q_MAGIC) >> Q_SHIFT, low by at most one
  localparam int MOD_BASE = 10000;
  localparam int Q_MAGIC  = 53687;
  localparam int Q_SHIFT  = 29;
  localparam int Q_W      = PROD_W - Q_SHIFT;
  localparam int REM_W    = 14;
  localparam int DIFF_W   = KEY_W + 1;

  // remainder div 100, exact below 43690
  localparam int PAIR_MAGIC = 5243;
  localparam int PAIR_SHIFT = 19;
  localparam int PAIR_W     = 7;

  // pair div 10, exact below 1029
  localparam int TEN_MAGIC = 205;
  localparam int TEN_SHIFT = 11;
  localparam int DIGIT_W   = 4;
  localparam int SUM_W     = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_Q,
    S_MUL_R,
    S_REM,
    S_MUL_P,
    S_MUL_T,
    S_BUCKET,
    S_SCAN,
    S_ACT
  } state_e;

  // flat slot address of one way of a bucket
  function automatic logic [SLOT_W-1:0] slot_addr(logic [BUCKET_W-1:0] bucket,
                                                  logic [WAY_W-1:0] way);
    slot_addr = SLOT_W'(SLOT_W'(bucket) * SLOT_W'(WAYS) + SLOT_W'(way));
  endfunction

endpackage

>>> rtl/kvs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvs_req_if: request channel of the key-value store
// Valid/ready handshake carrying operation, key and value.
// ----------------------------------------------------------------------------
interface kvs_req_if;
  logic                       valid;
  logic                       ready;
  logic [kvs_pkg::OP_W-1:0]   operation;
  logic [kvs_pkg::KEY_W-1:0]  key;
  logic [kvs_pkg::VAL_W-1:0]  value;

  modport source (output valid, output operation, output key, output value,
                  input ready);
  modport sink   (input valid, input operation, input key, input value,
                  output ready);
endinterface

>>> rtl/kvs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvs_rsp_if: response channel of the key-value store
// Valid/ready handshake carrying status, found value and entry count.
// ----------------------------------------------------------------------------
interface kvs_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [kvs_pkg::STATUS_W-1:0]   status;
  logic [kvs_pkg::VAL_W-1:0]      found_value;
  logic [kvs_pkg::CNT_OUT_W-1:0]  entry_count;

  modport source (output valid, output status, output found_value,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input found_value,
                  input entry_count, output ready);
endinterface

>>> rtl/bucketed_key_value_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_key_value_store_unit: hashed key-value table with fixed buckets
// Insert, lookup and remove of 31-bit keys with 16-bit values, one
// response per request.
// ----------------------------------------------------------------------------
// The store takes one request at a time and answers each one with a status,
// the found value and the entry count after the request. From acceptance to
// the next acceptance, the states S_MUL_Q to S_BUCKET hash the key's
// hundreds and thousands digits into a bucket using one shared multiplier
// in four passes, then each way of the bucket is read from the slot memory
// through its single read port (one way per cycle, after which the
// registered read and the last compare complete), then S_ACT applies the
// update and loads the response register, and S_IDLE takes the next
// request. The update waits for as long as an earlier response is still
// held in the response register. A new request is accepted while an
// earlier response still waits to be taken.
// The valid bits are flops cleared by reset, so no clearing pass runs and
// the store is usable right after reset. A bucket that has all ways taken
// refuses an insert as full.
// ----------------------------------------------------------------------------
module bucketed_key_value_store_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  kvs_req_if.sink   req_i,
  kvs_rsp_if.source rsp_o
);

  kvs_pkg::state_e state_q, state_d;

  // captured request
  logic [kvs_pkg::OP_W-1:0]  op_q;
  logic [kvs_pkg::KEY_W-1:0] key_q;
  logic [kvs_pkg::VAL_W-1:0] value_q;

  // shared multiplier and hash intermediates
  logic [kvs_pkg::MUL_A_W-1:0]  mul_a;
  logic [kvs_pkg::MUL_B_W-1:0]  mul_b;
  logic [kvs_pkg::PROD_W-1:0]   prod_q, prod_d;
  logic [kvs_pkg::DIFF_W-1:0]   diff;
  logic [kvs_pkg::REM_W-1:0]    rem_q, rem_d;
  logic [kvs_pkg::PAIR_W-1:0]   pair_q;
  logic [kvs_pkg::DIGIT_W-1:0]  tens, units;
  logic [kvs_pkg::PAIR_W-1:0]   tens_x10;
  logic [kvs_pkg::SUM_W-1:0]    dbl, dbl_mod, bucket_sum;
  logic [kvs_pkg::BUCKET_W-1:0] bucket_q, bucket_d;

  // slot storage
  logic [kvs_pkg::KV_W-1:0]        slot_mem_q [kvs_pkg::TOTAL_SLOTS];
  logic [kvs_pkg::TOTAL_SLOTS-1:0] slot_vld_q;
  logic [kvs_pkg::KV_W-1:0]        rd_kv_q;
  logic                            rd_vld_q;
  logic                            rd_en;
  logic [kvs_pkg::SLOT_W-1:0]      rd_addr;
  logic                            mem_we;
  logic [kvs_pkg::SLOT_W-1:0]      wr_addr;
  logic                            vld_set, vld_clr;
  logic [kvs_pkg::SLOT_W-1:0]      hit_addr;

  // scan bookkeeping
  logic [kvs_pkg::WAYC_W-1:0] issue_way_q;
  logic                       issue_more;
  logic                       rd_pend_q;
  logic [kvs_pkg::WAY_W-1:0]  rd_way_q;
  logic                       hit_q;
  logic [kvs_pkg::WAY_W-1:0]  hit_way_q;
  logic [kvs_pkg::VAL_W-1:0]  hit_val_q;
  logic                       free_q;
  logic [kvs_pkg::WAY_W-1:0]  free_way_q;
  logic                       key_match;

  // entry count and response
  logic [kvs_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                          out_free;
  logic                          act_fire;
  logic [kvs_pkg::STATUS_W-1:0]  status_d;
  logic [kvs_pkg::VAL_W-1:0]     found_d;
  logic                          rsp_valid_q;
  logic [kvs_pkg::STATUS_W-1:0]  rsp_status_q;
  logic [kvs_pkg::VAL_W-1:0]     rsp_found_q;
  logic [kvs_pkg::CNT_OUT_W-1:0] rsp_count_q;

  // handshake
  assign req_i.ready       = (state_q == kvs_pkg::S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found_value = rsp_found_q;
  assign rsp_o.entry_count = rsp_count_q;
  assign out_free          = !rsp_valid_q || rsp_o.ready;

  // scan helpers
  assign issue_more = (issue_way_q < kvs_pkg::WAYC_W'(kvs_pkg::WAYS));
  assign key_match  = rd_vld_q && (rd_kv_q[kvs_pkg::VAL_W +: kvs_pkg::KEY_W] == key_q);
  assign rd_addr    = kvs_pkg::slot_addr(bucket_q, issue_way_q[kvs_pkg::WAY_W-1:0]);
  assign hit_addr   = kvs_pkg::slot_addr(bucket_q, hit_way_q);

  // hash arithmetic around the shared multiplier
  assign prod_d   = mul_a * mul_b;
  assign diff     = {1'b0, key_q} - prod_q[kvs_pkg::DIFF_W-1:0];
  assign rem_d    = (diff >= kvs_pkg::DIFF_W'(kvs_pkg::MOD_BASE))
                  ? kvs_pkg::REM_W'(diff - kvs_pkg::DIFF_W'(kvs_pkg::MOD_BASE))
                  : kvs_pkg::REM_W'(diff);
  assign tens     = prod_q[kvs_pkg::TEN_SHIFT +: kvs_pkg::DIGIT_W];
  assign tens_x10 = kvs_pkg::PAIR_W'({tens, 3'b000}) + kvs_pkg::PAIR_W'({tens, 1'b0});
  assign units    = kvs_pkg::DIGIT_W'(pair_q - tens_x10);
  assign dbl      = {tens, 1'b0};
  assign dbl_mod  = (dbl >= kvs_pkg::SUM_W'(10)) ? dbl - kvs_pkg::SUM_W'(10) : dbl;
  assign bucket_sum = dbl_mod + kvs_pkg::SUM_W'(units);
  assign bucket_d   = kvs_pkg::BUCKET_W'(bucket_sum);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kvs_pkg::S_IDLE:   if (req_i.valid) state_d = kvs_pkg::S_MUL_Q;
      kvs_pkg::S_MUL_Q:  state_d = kvs_pkg::S_MUL_R;
      kvs_pkg::S_MUL_R:  state_d = kvs_pkg::S_REM;
      kvs_pkg::S_REM:    state_d = kvs_pkg::S_MUL_P;
      kvs_pkg::S_MUL_P:  state_d = kvs_pkg::S_MUL_T;
      kvs_pkg::S_MUL_T:  state_d = kvs_pkg::S_BUCKET;
      kvs_pkg::S_BUCKET: state_d = kvs_pkg::S_SCAN;
      kvs_pkg::S_SCAN:   if (!issue_more && !rd_pend_q) state_d = kvs_pkg::S_ACT;
      kvs_pkg::S_ACT:    if (out_free) state_d = kvs_pkg::S_IDLE;
      default:           state_d = kvs_pkg::S_IDLE;
    endcase
  end

  // multiplier operands, memory control and update decisions
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    rd_en    = 1'b0;
    act_fire = 1'b0;
    mem_we   = 1'b0;
    wr_addr  = kvs_pkg::slot_addr(bucket_q, free_way_q);
    vld_set  = 1'b0;
    vld_clr  = 1'b0;
    cnt_d    = cnt_q;
    status_d = kvs_pkg::ST_OK;
    found_d  = '0;
    case (state_q)
      kvs_pkg::S_MUL_Q: begin
        mul_a = key_q;
        mul_b = kvs_pkg::MUL_B_W'(kvs_pkg::Q_MAGIC);
      end
      kvs_pkg::S_MUL_R: begin
        mul_a = kvs_pkg::MUL_A_W'(prod_q[kvs_pkg::Q_SHIFT +: kvs_pkg::Q_W]);
        mul_b = kvs_pkg::MUL_B_W'(kvs_pkg::MOD_BASE);
      end
      kvs_pkg::S_MUL_P: begin
        mul_a = kvs_pkg::MUL_A_W'(rem_q);
        mul_b = kvs_pkg::MUL_B_W'(kvs_pkg::PAIR_MAGIC);
      end
      kvs_pkg::S_MUL_T: begin
        mul_a = kvs_pkg::MUL_A_W'(prod_q[kvs_pkg::PAIR_SHIFT +: kvs_pkg::PAIR_W]);
        mul_b = kvs_pkg::MUL_B_W'(kvs_pkg::TEN_MAGIC);
      end
      kvs_pkg::S_SCAN: begin
        rd_en = issue_more;
      end
      kvs_pkg::S_ACT: begin
        act_fire = out_free;
        case (op_q)
          kvs_pkg::OP_INSERT: begin
            if (hit_q) begin
              status_d = kvs_pkg::ST_DUPLICATE;
            end else if (free_q) begin
              mem_we  = act_fire;
              vld_set = act_fire;
              cnt_d   = cnt_q + kvs_pkg::CNT_W'(1);
            end else begin
              status_d = kvs_pkg::ST_FULL;
            end
          end
          kvs_pkg::OP_LOOKUP: begin
            if (hit_q) begin
              found_d = hit_val_q;
            end else begin
              status_d = kvs_pkg::ST_NOT_FOUND;
            end
          end
          kvs_pkg::OP_REMOVE: begin
            if (hit_q) begin
              vld_clr = act_fire;
              if (cnt_q != '0) cnt_d = cnt_q - kvs_pkg::CNT_W'(1);
            end else begin
              status_d = kvs_pkg::ST_NOT_FOUND;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kvs_pkg::S_IDLE;
      slot_vld_q  <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
      issue_way_q <= '0;
      rd_pend_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      state_q <= state_d;

      // valid bits and count
      if (vld_set) slot_vld_q[wr_addr]  <= 1'b1;
      if (vld_clr) slot_vld_q[hit_addr] <= 1'b0;
      if (act_fire) cnt_q <= cnt_d;

      // response valid
      if (act_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end

      // scan progress and results
      if (state_q == kvs_pkg::S_BUCKET) begin
        issue_way_q <= '0;
        rd_pend_q   <= 1'b0;
        hit_q       <= 1'b0;
        free_q      <= 1'b0;
      end else begin
        rd_pend_q <= rd_en;
        if (rd_en) issue_way_q <= issue_way_q + kvs_pkg::WAYC_W'(1);
        if (rd_pend_q && key_match && !hit_q) hit_q <= 1'b1;
        if (rd_pend_q && !rd_vld_q && !free_q) free_q <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q    <= req_i.operation;
      key_q   <= req_i.key;
      value_q <= req_i.value;
    end
    prod_q <= prod_d;
    if (state_q == kvs_pkg::S_REM) rem_q <= rem_d;
    if (state_q == kvs_pkg::S_MUL_T) pair_q <= prod_q[kvs_pkg::PAIR_SHIFT +: kvs_pkg::PAIR_W];
    if (state_q == kvs_pkg::S_BUCKET) bucket_q <= bucket_d;

    // scan captures
    if (rd_en) begin
      rd_way_q <= issue_way_q[kvs_pkg::WAY_W-1:0];
      rd_vld_q <= slot_vld_q[rd_addr];
    end
    if (rd_pend_q && key_match && !hit_q) begin
      hit_way_q <= rd_way_q;
      hit_val_q <= rd_kv_q[kvs_pkg::VAL_W-1:0];
    end
    if (rd_pend_q && !rd_vld_q && !free_q) free_way_q <= rd_way_q;

    // response payload
    if (act_fire) begin
      rsp_status_q <= status_d;
      rsp_found_q  <= found_d;
      rsp_count_q  <= (cnt_d > kvs_pkg::CNT_W'(kvs_pkg::CNT_OUT_MAX))
                    ? {kvs_pkg::CNT_OUT_W{1'b1}} : kvs_pkg::CNT_OUT_W'(cnt_d);
    end
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) slot_mem_q[wr_addr] <= {key_q, value_q};
    if (rd_en) rd_kv_q <= slot_mem_q[rd_addr];
  end

endmodule
